>>> hdl/comb_enum_pkg.sv
// Shared types and constants for the combination enumerator.
package comb_enum_pkg;

  localparam int VALUE_W     = 32;
  localparam int POS_W       = 3;
  localparam int CMD_W       = 2;
  localparam int MODE_W      = 2;
  localparam int ENTRY_IDX_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  // most elements one combination may hold (one per result slot)
  localparam int RESULT_CAP  = 8;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LEX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ANTI  = 2'd2;
  // unused code, treated as lexicographic
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic tbl_we;
    logic first_load;
    logic scan_init;
    logic scan_step;
    logic advance;
    logic pos_clear;
    logic pos_step;
    logic out_elem;
    logic out_exh;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_ok;
    logic hit;
    logic scan_last;
    logic pos_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/comb_enum_dp.sv
// Datapath: config registers, source table, index tuple, scan/emit counters, output register.
module comb_enum_dp #(
  parameter int MAX_ITEMS = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [comb_enum_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [comb_enum_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [comb_enum_pkg::ENTRY_IDX_W-1:0]    entry_index_i,
  input  logic signed [comb_enum_pkg::VALUE_W-1:0] entry_value_i,
  input  logic                                     out_ready_i,
  input  comb_enum_pkg::dp_cmd_t                   cmd_i,
  output comb_enum_pkg::dp_stat_t                  stat_o,
  output logic                                     out_valid_o,
  output logic signed [comb_enum_pkg::VALUE_W-1:0] element_value_o,
  output logic [comb_enum_pkg::POS_W-1:0]          position_o,
  output logic                                     last_of_combination_o,
  output logic                                     exhausted_o
);

  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int CW0   = $clog2(MAX_ITEMS + 1) + 1;
  localparam int CW    = (CW0 > 5) ? CW0 : 5;
  localparam int K_LIM = (MAX_ITEMS < comb_enum_pkg::RESULT_CAP) ?
                         MAX_ITEMS : comb_enum_pkg::RESULT_CAP;

  logic [comb_enum_pkg::CFG_DATA_W-1:0] set_size_q, pick_count_q;
  logic [comb_enum_pkg::MODE_W-1:0]     order_mode_q;

  logic [comb_enum_pkg::VALUE_W-1:0] tbl_q [MAX_ITEMS];
  logic [IW-1:0]                     sel_q [MAX_ITEMS];
  logic [IW-1:0]                     sel_d [MAX_ITEMS];
  logic [IW-1:0]                     scan_q, scan_d;
  logic [comb_enum_pkg::POS_W-1:0]   pos_q, pos_d;

  logic                                     out_valid_q, out_valid_d;
  logic signed [comb_enum_pkg::VALUE_W-1:0] value_q;
  logic [comb_enum_pkg::POS_W-1:0]          position_q;
  logic                                     last_q, exh_q;

  logic [comb_enum_pkg::MODE_W-1:0] mode;
  logic [CW-1:0] n_c, k_c, scan_c, piv_c, pos_c;
  logic [IW-1:0] piv_v;

  // effective sizes and mode
  always_comb begin
    mode = (order_mode_q == comb_enum_pkg::MODE_ALIAS) ? comb_enum_pkg::MODE_LEX : order_mode_q;
    n_c  = (CW'(set_size_q) > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(set_size_q);
    k_c  = (CW'(pick_count_q) > CW'(K_LIM)) ? CW'(K_LIM) : CW'(pick_count_q);
    scan_c = CW'(scan_q);
    piv_v  = sel_q[scan_q];
    piv_c  = CW'(piv_v);
    pos_c  = CW'(pos_q);
  end

  always_comb begin
    stat_o.first_ok = (n_c != '0) && (k_c != '0) &&
                      ((mode == comb_enum_pkg::MODE_REP) || (k_c <= n_c));
    unique case (mode)
      comb_enum_pkg::MODE_REP: begin
        stat_o.hit       = (piv_c + CW'(1)) < n_c;
        stat_o.scan_last = (scan_c == '0);
      end
      comb_enum_pkg::MODE_ANTI: begin
        stat_o.hit       = piv_c > scan_c;
        stat_o.scan_last = (scan_c == k_c - CW'(1));
      end
      default: begin
        stat_o.hit       = (piv_c + k_c) < (n_c + scan_c);
        stat_o.scan_last = (scan_c == '0);
      end
    endcase
    stat_o.pos_last = (pos_c == k_c - CW'(1));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // next index tuple: each element set on its own, initially or from the pivot
  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      sel_d[j] = sel_q[j];
      if (cmd_i.first_load) begin
        unique case (mode)
          comb_enum_pkg::MODE_REP:  sel_d[j] = '0;
          comb_enum_pkg::MODE_ANTI: sel_d[j] = IW'(n_c - k_c + CW'(j));
          default:                  sel_d[j] = IW'(j);
        endcase
      end else if (cmd_i.advance) begin
        unique case (mode)
          comb_enum_pkg::MODE_REP: begin
            if (CW'(j) >= scan_c) sel_d[j] = IW'(piv_c + CW'(1));
          end
          comb_enum_pkg::MODE_ANTI: begin
            if (CW'(j) <= scan_c) sel_d[j] = IW'(piv_c + CW'(j) - scan_c - CW'(1));
          end
          default: begin
            if (CW'(j) >= scan_c) sel_d[j] = IW'(piv_c + CW'(j) - scan_c + CW'(1));
          end
        endcase
      end
    end
  end

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.scan_init) begin
      scan_d = (mode == comb_enum_pkg::MODE_ANTI) ? '0 : IW'(k_c - CW'(1));
    end else if (cmd_i.scan_step) begin
      scan_d = (mode == comb_enum_pkg::MODE_ANTI) ? scan_q + IW'(1) : scan_q - IW'(1);
    end
    pos_d = pos_q;
    if (cmd_i.pos_clear) begin
      pos_d = '0;
    end else if (cmd_i.pos_step) begin
      pos_d = pos_q + comb_enum_pkg::POS_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.out_elem || cmd_i.out_exh) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q   <= 4'd4;
      pick_count_q <= 4'd3;
      order_mode_q <= comb_enum_pkg::MODE_LEX;
      for (int j = 0; j < MAX_ITEMS; j++) sel_q[j] <= '0;
      scan_q       <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          comb_enum_pkg::CFG_SET_SIZE:   set_size_q   <= cfg_wdata_i;
          comb_enum_pkg::CFG_PICK_COUNT: pick_count_q <= cfg_wdata_i;
          comb_enum_pkg::CFG_ORDER_MODE: order_mode_q <= cfg_wdata_i[comb_enum_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      for (int j = 0; j < MAX_ITEMS; j++) sel_q[j] <= sel_d[j];
      scan_q      <= scan_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we && (int'(entry_index_i) < MAX_ITEMS)) begin
      tbl_q[IW'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.out_elem) begin
      value_q    <= tbl_q[sel_q[IW'(pos_q)]];
      position_q <= pos_q;
      last_q     <= stat_o.pos_last;
      exh_q      <= 1'b0;
    end else if (cmd_i.out_exh) begin
      value_q    <= '0;
      position_q <= '0;
      last_q     <= 1'b1;
      exh_q      <= 1'b1;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign element_value_o       = value_q;
  assign position_o            = position_q;
  assign last_of_combination_o = last_q;
  assign exhausted_o           = exh_q;

endmodule

>>> hdl/comb_enum_ctrl.sv
// Controller: command decode, started/done flags, scan and emit sequencing.
module comb_enum_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [comb_enum_pkg::CMD_W-1:0]      cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [comb_enum_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  comb_enum_pkg::dp_stat_t              stat_i,
  output comb_enum_pkg::dp_cmd_t               cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_EXH  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       started_q, started_d;
  logic       done_q, done_d;
  logic       cfg_hit;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == comb_enum_pkg::CFG_SET_SIZE) ||
                                (cfg_index_i == comb_enum_pkg::CFG_PICK_COUNT) ||
                                (cfg_index_i == comb_enum_pkg::CFG_ORDER_MODE));

  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    done_d     = done_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd_i)
            comb_enum_pkg::CMD_LOAD: cmd_o.tbl_we = 1'b1;
            comb_enum_pkg::CMD_RESTART: begin
              started_d = 1'b0;
              done_d    = 1'b0;
            end
            comb_enum_pkg::CMD_NEXT: begin
              if (done_q) begin
                state_d = S_EXH;
              end else if (!started_q) begin
                started_d = 1'b1;
                if (stat_i.first_ok) begin
                  cmd_o.first_load = 1'b1;
                  cmd_o.pos_clear  = 1'b1;
                  state_d          = S_EMIT;
                end else begin
                  done_d  = 1'b1;
                  state_d = S_EXH;
                end
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.advance   = 1'b1;
          cmd_o.pos_clear = 1'b1;
          state_d         = S_EMIT;
        end else if (stat_i.scan_last) begin
          done_d  = 1'b1;
          state_d = S_EXH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_elem = 1'b1;
          if (stat_i.pos_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pos_step = 1'b1;
          end
        end
      end
      S_EXH: begin
        if (stat_i.out_free) begin
          cmd_o.out_exh = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a write to a used config register starts the enumeration over
    if (cfg_hit) begin
      started_d = 1'b0;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      done_q    <= done_d;
    end
  end

endmodule

>>> hdl/combination_enumerator.sv
// Top level of the combination enumerator: controller, datapath and checks.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_ready_o  cmd_i, entry_index_i, entry_value_i
//  out      source     out_valid_o/out_ready_i element_value_o, position_o,
//                                             last_of_combination_o, exhausted_o
//  cfg      sink       cfg_we_i (no wait)     cfg_index_i, cfg_wdata_i
//
// Load and restart are taken in idle and leave the controller idle. A next is accepted in idle,
// then emits one element per cycle through the output register while the output is not stalled;
// after the first combination a pivot scan (one tuple position per cycle) comes before the emit.
// The exhausted marker goes out from its own state once done or when a scan runs out.
// Reset leaves the flags cleared and the config at n=4, k=3, lexicographic order.
// Output stalls hold the emit sequence; the next transaction is taken once emission ends.
module combination_enumerator #(
  parameter int MAX_ITEMS = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [comb_enum_pkg::CMD_W-1:0]          cmd_i,
  input  logic [comb_enum_pkg::ENTRY_IDX_W-1:0]    entry_index_i,
  input  logic signed [comb_enum_pkg::VALUE_W-1:0] entry_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [comb_enum_pkg::VALUE_W-1:0] element_value_o,
  output logic [comb_enum_pkg::POS_W-1:0]          position_o,
  output logic                                     last_of_combination_o,
  output logic                                     exhausted_o,
  input  logic                                     cfg_we_i,
  input  logic [comb_enum_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [comb_enum_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  comb_enum_pkg::dp_cmd_t  dp_cmd;
  comb_enum_pkg::dp_stat_t dp_stat;

  comb_enum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  comb_enum_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .entry_index_i         (entry_index_i),
    .entry_value_i         (entry_value_i),
    .out_ready_i           (out_ready_i),
    .cmd_i                 (dp_cmd),
    .stat_o                (dp_stat),
    .out_valid_o           (out_valid_o),
    .element_value_o       (element_value_o),
    .position_o            (position_o),
    .last_of_combination_o (last_of_combination_o),
    .exhausted_o           (exhausted_o)
  );

  // exhausted marker carries a fixed shape
  a_exh_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |->
      last_of_combination_o && (position_o == '0) && (element_value_o == '0))
    else $error("exhausted marker malformed");

  // load, restart and unknown commands leave the input ready in the next cycle
  a_short_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i != comb_enum_pkg::CMD_NEXT) |=> in_ready_o)
    else $error("short command held the input");

  // a next transaction blocks the input while it works
  a_next_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == comb_enum_pkg::CMD_NEXT) |=> !in_ready_o)
    else $error("input accepted during a next");

  // elements of one combination come back to back with rising position
  a_pos_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_combination_o |=>
      out_valid_o && !exhausted_o &&
      (position_o == $past(position_o) + comb_enum_pkg::POS_W'(1)))
    else $error("element sequence broken");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the combination enumerator.
`timescale 1ns / 1ps

module testbench;

  localparam int TBL_DEPTH     = 8;
  localparam int SETTLE_CYCLES = 24;   // covers the longest next: accept, full pivot scan and emit
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [comb_enum_pkg::CMD_W-1:0]     CMD_IGNORED = 2'd3;
  localparam logic [comb_enum_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  typedef struct packed {
    logic signed [comb_enum_pkg::VALUE_W-1:0] value;
    logic [comb_enum_pkg::POS_W-1:0]          pos;
    logic                                     last;
    logic                                     exh;
  } elem_t;

  logic                                     clk_i         = 1'b0;
  logic                                     rst_ni        = 1'b0;
  logic                                     in_valid_i    = 1'b0;
  logic                                     in_ready_o;
  logic [comb_enum_pkg::CMD_W-1:0]          cmd_i         = comb_enum_pkg::CMD_LOAD;
  logic [comb_enum_pkg::ENTRY_IDX_W-1:0]    entry_index_i = '0;
  logic signed [comb_enum_pkg::VALUE_W-1:0] entry_value_i = '0;
  logic                                     out_valid_o;
  logic                                     out_ready_i   = 1'b0;
  logic signed [comb_enum_pkg::VALUE_W-1:0] element_value_o;
  logic [comb_enum_pkg::POS_W-1:0]          position_o;
  logic                                     last_of_combination_o;
  logic                                     exhausted_o;
  logic                                     cfg_we_i      = 1'b0;
  logic [comb_enum_pkg::CFG_IDX_W-1:0]      cfg_index_i   = comb_enum_pkg::CFG_SET_SIZE;
  logic [comb_enum_pkg::CFG_DATA_W-1:0]     cfg_wdata_i   = '0;

  // predictor state
  logic signed [comb_enum_pkg::VALUE_W-1:0] src_tbl [TBL_DEPTH];
  int                                       sel_idx [TBL_DEPTH];
  bit                                       combo_started = 1'b0;
  bit                                       combo_done    = 1'b0;
  logic [comb_enum_pkg::CFG_DATA_W-1:0]     cfg_n         = 4'd4;
  logic [comb_enum_pkg::CFG_DATA_W-1:0]     cfg_k         = 4'd3;
  logic [comb_enum_pkg::MODE_W-1:0]         cfg_mode      = comb_enum_pkg::MODE_LEX;
  elem_t                                    pending_elems [$];

  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int items_sent   = 0;
  int stall_cnt    = 0;
  bit idle_en      = 1'b0;
  bit stall_en     = 1'b0;

  combination_enumerator #(
    .MAX_ITEMS(TBL_DEPTH)
  ) i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .cmd_i                (cmd_i),
    .entry_index_i        (entry_index_i),
    .entry_value_i        (entry_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .element_value_o      (element_value_o),
    .position_o           (position_o),
    .last_of_combination_o(last_of_combination_o),
    .exhausted_o          (exhausted_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output backpressure: random stall bursts
  always @(posedge clk_i) begin
    if (stall_cnt != 0) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= stall_cnt - 1;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit subset_first(input int md, input int n, input int k);
    if (n == 0 || k == 0) return 1'b0;
    if (md != int'(comb_enum_pkg::MODE_REP) && k > n) return 1'b0;
    for (int i = 0; i < k; i++) begin
      if (md == int'(comb_enum_pkg::MODE_LEX)) sel_idx[i] = i;
      else if (md == int'(comb_enum_pkg::MODE_REP)) sel_idx[i] = 0;
      else sel_idx[i] = n - k + i;
    end
    return 1'b1;
  endfunction

  function automatic bit subset_step(input int md, input int n, input int k);
    if (md == int'(comb_enum_pkg::MODE_LEX)) begin
      for (int i = k - 1; i >= 0; i--) begin
        if (sel_idx[i] < n - k + i) begin
          sel_idx[i]++;
          for (int j = i + 1; j < k; j++) sel_idx[j] = sel_idx[j-1] + 1;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (md == int'(comb_enum_pkg::MODE_REP)) begin
      for (int i = k - 1; i >= 0; i--) begin
        if (sel_idx[i] < n - 1) begin
          sel_idx[i]++;
          for (int j = i + 1; j < k; j++) sel_idx[j] = sel_idx[i];
          return 1'b1;
        end
      end
      return 1'b0;
    end
    // anti-lexicographic: lowest position that can move down does
    for (int i = 0; i < k; i++) begin
      if (sel_idx[i] > i) begin
        sel_idx[i]--;
        for (int j = i - 1; j >= 0; j--) sel_idx[j] = sel_idx[j+1] - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_item(input logic [comb_enum_pkg::CMD_W-1:0] cmd,
                                       input logic [comb_enum_pkg::ENTRY_IDX_W-1:0] idx,
                                       input logic signed [comb_enum_pkg::VALUE_W-1:0] val);
    int    md;
    int    n;
    int    k;
    bit    ok;
    elem_t e;
    case (cmd)
      comb_enum_pkg::CMD_LOAD: src_tbl[idx] = val;
      comb_enum_pkg::CMD_RESTART: begin
        combo_started = 1'b0;
        combo_done    = 1'b0;
      end
      comb_enum_pkg::CMD_NEXT: begin
        md = (cfg_mode == comb_enum_pkg::MODE_ALIAS) ? int'(comb_enum_pkg::MODE_LEX) :
                                                       int'(cfg_mode);
        n  = (int'(cfg_n) > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_n);
        k  = (int'(cfg_k) > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_k);
        if (k > comb_enum_pkg::RESULT_CAP) k = comb_enum_pkg::RESULT_CAP;
        if (combo_done) begin
          ok = 1'b0;
        end else if (!combo_started) begin
          ok = subset_first(md, n, k);
          combo_started = 1'b1;
        end else begin
          ok = subset_step(md, n, k);
        end
        if (!ok) begin
          combo_done = 1'b1;
          e = '{value: '0, pos: '0, last: 1'b1, exh: 1'b1};
          pending_elems.push_back(e);
        end else begin
          for (int i = 0; i < k; i++) begin
            e = '{value: src_tbl[sel_idx[i]], pos: i[comb_enum_pkg::POS_W-1:0],
                  last: (i == k - 1), exh: 1'b0};
            pending_elems.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : check_elems
    elem_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_elems.size() == 0) begin
        note_mismatch($sformatf("unexpected element: value=%0d pos=%0d last=%0b exh=%0b",
                                element_value_o, position_o, last_of_combination_o,
                                exhausted_o));
      end else begin
        want = pending_elems.pop_front();
        if (element_value_o !== want.value || position_o !== want.pos ||
            last_of_combination_o !== want.last || exhausted_o !== want.exh) begin
          note_mismatch($sformatf({"element mismatch: expected value=%0d pos=%0d ",
                                   "last=%0b exh=%0b, got value=%0d pos=%0d last=%0b exh=%0b"},
                                  want.value, want.pos, want.last, want.exh,
                                  element_value_o, position_o, last_of_combination_o,
                                  exhausted_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [comb_enum_pkg::CMD_W-1:0] cmd,
                           input logic [comb_enum_pkg::ENTRY_IDX_W-1:0] idx,
                           input logic signed [comb_enum_pkg::VALUE_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= idx;
    entry_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(cmd, idx, val);
    items_sent++;
  endtask

  // drop valid, wait for all elements plus the tail of any load or restart
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [comb_enum_pkg::CFG_IDX_W-1:0] idx,
                           input logic [comb_enum_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      comb_enum_pkg::CFG_SET_SIZE:   cfg_n = data;
      comb_enum_pkg::CFG_PICK_COUNT: cfg_k = data;
      comb_enum_pkg::CFG_ORDER_MODE: cfg_mode = data[comb_enum_pkg::MODE_W-1:0];
      default: ;
    endcase
    if (idx != CFG_UNUSED) begin
      combo_started = 1'b0;
      combo_done    = 1'b0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [comb_enum_pkg::CFG_DATA_W-1:0] n,
                              input logic [comb_enum_pkg::CFG_DATA_W-1:0] k,
                              input logic [comb_enum_pkg::CFG_DATA_W-1:0] md);
    drain();
    write_reg(comb_enum_pkg::CFG_SET_SIZE, n);
    write_reg(comb_enum_pkg::CFG_PICK_COUNT, k);
    write_reg(comb_enum_pkg::CFG_ORDER_MODE, md);
  endtask

  function automatic logic signed [comb_enum_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [comb_enum_pkg::ENTRY_IDX_W-1:0] rand_idx();
    int r;
    r = $urandom;
    return r[comb_enum_pkg::ENTRY_IDX_W-1:0];
  endfunction

  // mostly small sizes so enumerations run out within a phase
  function automatic logic [comb_enum_pkg::CFG_DATA_W-1:0] rand_size();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 6) v = $urandom_range(1, 5);
    else if (r < 9) v = $urandom_range(6, 8);
    else v = $urandom_range(0, 15);
    return v[comb_enum_pkg::CFG_DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_defaults_and_table();
    idle_en  = 1'b1;
    stall_en = 1'b1;
    send_item(comb_enum_pkg::CMD_LOAD, 3'd0, 32'sh8000_0000);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd1, 32'sh7fff_ffff);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd2, '0);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd3, -32'sd1);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd4, 32'sh5555_5555);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd5, 32'shaaaa_aaaa);
    send_item(comb_enum_pkg::CMD_LOAD, 3'd6, rand_value());
    send_item(comb_enum_pkg::CMD_LOAD, 3'd7, rand_value());
    // reset config n=4 k=3: four combinations, then the exhausted marker twice
    repeat (6) send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    send_item(CMD_IGNORED, rand_idx(), rand_value());
    send_item(comb_enum_pkg::CMD_RESTART, rand_idx(), rand_value());
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    // a load mid-enumeration, of an entry that the following combination does not select
    send_item(comb_enum_pkg::CMD_LOAD, 3'd2, rand_value());
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
  endtask

  task automatic test_order_modes();
    // repetition allows k above n
    apply_config(4'd2, 4'd3, 4'(comb_enum_pkg::MODE_REP));
    repeat (2) send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    apply_config(4'd4, 4'd2, 4'(comb_enum_pkg::MODE_ANTI));
    repeat (2) send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    apply_config(4'd3, 4'd2, 4'(comb_enum_pkg::MODE_ALIAS));
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    // no subsets at all
    apply_config(4'd2, 4'd3, 4'(comb_enum_pkg::MODE_LEX));
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    apply_config(4'd0, 4'd2, 4'(comb_enum_pkg::MODE_LEX));
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    apply_config(4'd3, 4'd0, 4'(comb_enum_pkg::MODE_ANTI));
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    // both saturate to eight
    apply_config(4'd15, 4'd15, 4'(comb_enum_pkg::MODE_REP));
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
    drain();
    write_reg(CFG_UNUSED, 4'hf);            // must not restart
    send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
  endtask

  task automatic run_phase(input int len, input bit gaps);
    int r;
    int m;
    m = $urandom_range(0, 15);
    apply_config(rand_size(), rand_size(), m[comb_enum_pkg::CFG_DATA_W-1:0]);
    idle_en  = gaps;
    stall_en = gaps;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) send_item(comb_enum_pkg::CMD_NEXT, rand_idx(), rand_value());
      else if (r < 86) send_item(comb_enum_pkg::CMD_LOAD, rand_idx(), rand_value());
      else if (r < 94) send_item(comb_enum_pkg::CMD_RESTART, rand_idx(), rand_value());
      else send_item(CMD_IGNORED, rand_idx(), rand_value());
    end
  endtask

  task automatic test_random_traffic();
    while (items_sent < 280) run_phase($urandom_range(15, 35), 1'b1);
  endtask

  task automatic test_steady_stream();
    repeat (2) run_phase(25, 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_and_table();
    test_order_modes();
    test_random_traffic();
    test_steady_stream();
    drain();
    if (mismatch_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
